[sv/dtp_pkg.sv]
`default_nettype none
package dtp_pkg;

	localparam int CharW = 8;
	localparam int IntW  = 32;
	localparam int FracW = 30;
	localparam int CntW  = 4;

	localparam logic [CntW-1:0]  MaxFracDigits = 4'd9;
	localparam logic [CharW-1:0] DotChar       = 8'h2E;
	localparam logic [CharW-1:0] ZeroChar      = 8'h30;
	localparam logic [CharW-1:0] NineChar      = 8'h39;

	typedef enum logic [1:0] {
		KIND_INVALID = 2'd0,
		KIND_INTEGER = 2'd1,
		KIND_DECIMAL = 2'd2
	} kind_t;

	typedef enum logic {
		PH_INT  = 1'b0,
		PH_FRAC = 1'b1
	} phase_t;

	// finished token, before the fraction is scaled
	typedef struct packed {
		kind_t             kind;
		logic [IntW-1:0]   integral;
		logic [FracW-1:0]  frac_acc;
		logic [CntW-1:0]   digits;
	} tok_t;

	// ten to the power of the missing fraction digits
	function automatic logic [FracW-1:0] scale_of(input logic [CntW-1:0] n);
		logic [FracW-1:0] s;
		unique case (n)
			4'd0:    s = 30'd1000000000;
			4'd1:    s = 30'd100000000;
			4'd2:    s = 30'd10000000;
			4'd3:    s = 30'd1000000;
			4'd4:    s = 30'd100000;
			4'd5:    s = 30'd10000;
			4'd6:    s = 30'd1000;
			4'd7:    s = 30'd100;
			4'd8:    s = 30'd10;
			default: s = 30'd1;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[sv/decimal_token_parser_core.sv]
`default_nettype none
// channel | dir | tdata                                     | tlast     | tuser
// s_      | in  | [7:0] char_code                           | last_char | -
// m_      | out | [31:0] whole_value, [61:32] fraction_nanos | -         | [1:0] kind
//
// one character per cycle sustained unless m_ stalls; m_tvalid rises once the last
// character has passed the input register, character step and scaling multiply
// the multiply-by-ten accumulate in the character step sets the pace
// reset clears the token state and all valid flags
// with m_ stalled, s_tready drops only once a last beat waits behind two held results
module decimal_token_parser_core
	import dtp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // last_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [31:0] whole_value, [61:32] fraction_nanos
	output logic [1:0]       m_tuser    // [1:0] kind
);

	logic             valid_s1, last_s1;
	logic [CharW-1:0] char_s1;
	logic             valid_s2;
	tok_t             tok_s2;
	tok_t             tok;
	logic             out_valid_q;
	kind_t            kind_q;
	logic [IntW-1:0]  int_q;
	logic [FracW-1:0] frac_q;

	logic             out_free, s2_free, s1_take, s1_free;
	logic [FracW-1:0] prod;

	assign out_free = !out_valid_q || m_tready;
	assign s2_free  = !valid_s2 || out_free;
	// a beat without last needs no room downstream
	assign s1_take  = valid_s1 && (!last_s1 || s2_free);
	assign s1_free  = !valid_s1 || s1_take;
	assign s_tready = s1_free;

	dtp_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (s1_take),
		.char_code (char_s1),
		.last_char (last_s1),
		.tok       (tok)
	);

	// only the low bits are kept
	assign prod = tok_s2.frac_acc * scale_of(tok_s2.digits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= s_tvalid;
			end
			if (s2_free) begin
				valid_s2 <= s1_take && last_s1;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && s_tvalid) begin
			char_s1 <= s_tdata[CharW-1:0];
			last_s1 <= s_tlast;
		end
		if (s2_free && s1_take && last_s1) begin
			tok_s2 <= tok;
		end
		if (out_free && valid_s2) begin
			kind_q <= tok_s2.kind;
			int_q  <= tok_s2.integral;
			frac_q <= prod;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, frac_q, int_q};
	assign m_tuser  = kind_q;

endmodule
`default_nettype wire

[sv/dtp_accum.sv]
`default_nettype none
module dtp_accum
	import dtp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire logic [CharW-1:0] char_code,
	input  wire logic             last_char,
	output tok_t                  tok
);

	phase_t            phase_q, phase_n;
	logic [IntW-1:0]   int_q, int_n;
	logic [FracW-1:0]  frac_q, frac_n;
	logic [CntW-1:0]   cnt_q, cnt_n;
	logic              err_q, err_n;

	logic              is_digit;
	logic [3:0]        digit;
	logic [IntW+3:0]   int_x10;
	logic [FracW-1:0]  frac_x10;

	assign is_digit = (char_code >= ZeroChar) && (char_code <= NineChar);
	assign digit    = 4'(char_code - ZeroChar);
	// times ten as shift-add, four extra bits show overflow
	assign int_x10  = {1'b0, int_q, 3'b000} + {3'b000, int_q, 1'b0} + {32'd0, digit};
	assign frac_x10 = {frac_q[FracW-4:0], 3'b000} + {frac_q[FracW-2:0], 1'b0}
	                  + {26'd0, digit};

	always_comb begin
		phase_n = phase_q;
		int_n   = int_q;
		frac_n  = frac_q;
		cnt_n   = cnt_q;
		err_n   = err_q;
		if (is_digit) begin
			if (phase_q == PH_INT) begin
				if (|int_x10[IntW+3:IntW]) begin
					err_n = 1'b1;
				end else begin
					int_n = int_x10[IntW-1:0];
				end
			end else if (cnt_q >= MaxFracDigits) begin
				err_n = 1'b1;
			end else begin
				frac_n = frac_x10;
				cnt_n  = cnt_q + 4'd1;
			end
		end else if (char_code == DotChar && phase_q == PH_INT) begin
			phase_n = PH_FRAC;
		end else begin
			err_n = 1'b1;
		end

		if (err_n) begin
			tok.kind     = KIND_INVALID;
			tok.integral = '0;
			tok.frac_acc = '0;
		end else if (phase_n == PH_INT) begin
			tok.kind     = KIND_INTEGER;
			tok.integral = int_n;
			tok.frac_acc = '0;
		end else begin
			tok.kind     = KIND_DECIMAL;
			tok.integral = int_n;
			tok.frac_acc = frac_n;
		end
		tok.digits = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INT;
			int_q   <= '0;
			frac_q  <= '0;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else if (take) begin
			if (last_char) begin
				phase_q <= PH_INT;
				int_q   <= '0;
				frac_q  <= '0;
				cnt_q   <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				int_q   <= int_n;
				frac_q  <= frac_n;
				cnt_q   <= cnt_n;
				err_q   <= err_n;
			end
		end
	end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top
	import dtp_pkg::*;
;

	typedef struct {
		kind_t            kind;
		logic [IntW-1:0]  integral;
		logic [FracW-1:0] nanos;
	} token_result_t;

	class token_tracker;
		phase_t           phase;
		logic [IntW-1:0]  int_acc;
		logic [FracW-1:0] frac_acc;
		logic [CntW-1:0]  frac_digits;
		logic             bad;
		token_result_t    expected_tokens[$];
		int               mismatches;

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			phase       = PH_INT;
			int_acc     = '0;
			frac_acc    = '0;
			frac_digits = '0;
			bad         = 1'b0;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $realtime, what);
		endfunction

		// one accepted character; the last one of a token queues its result
		function void note_char(logic [CharW-1:0] c, logic last);
			logic [IntW+3:0] wide;
			logic [3:0]      d;
			token_result_t   res;
			if (c >= ZeroChar && c <= NineChar) begin
				d = 4'(c - ZeroChar);
				if (phase == PH_INT) begin
					wide = int_acc * 36'd10 + d;
					if (wide[IntW+3:IntW] != 0)
						bad = 1'b1;
					else
						int_acc = wide[IntW-1:0];
				end else if (frac_digits >= MaxFracDigits) begin
					bad = 1'b1;
				end else begin
					frac_acc = frac_acc * 30'd10 + d;
					frac_digits++;
				end
			end else if (c == DotChar && phase == PH_INT) begin
				phase = PH_FRAC;
			end else begin
				bad = 1'b1;
			end
			if (last) begin
				res.integral = '0;
				res.nanos    = '0;
				if (bad) begin
					res.kind = KIND_INVALID;
				end else if (phase == PH_INT) begin
					res.kind     = KIND_INTEGER;
					res.integral = int_acc;
				end else begin
					res.kind     = KIND_DECIMAL;
					res.integral = int_acc;
					// pad the fraction out to nine digits
					res.nanos    = frac_acc;
					for (int i = frac_digits; i < MaxFracDigits; i++)
						res.nanos = res.nanos * 30'd10;
				end
				expected_tokens.push_back(res);
				clear();
			end
		endfunction

		function void check_result(logic [1:0] kind, logic [IntW-1:0] integral,
				logic [FracW-1:0] nanos);
			token_result_t want;
			if (expected_tokens.size() == 0) begin
				flag($sformatf("result beat with nothing expected: kind %0d int %0d nanos %0d",
					kind, integral, nanos));
				return;
			end
			want = expected_tokens.pop_front();
			if (kind !== want.kind)
				flag($sformatf("kind: expected %0d, got %0d", want.kind, kind));
			if (integral !== want.integral)
				flag($sformatf("whole_value: expected %0d, got %0d", want.integral, integral));
			if (nanos !== want.nanos)
				flag($sformatf("fraction_nanos: expected %0d, got %0d", want.nanos, nanos));
		endfunction
	endclass

	localparam int StallLimit = 1000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;

	token_tracker     sb = new();
	logic [CharW-1:0] token_chars[$];
	int               chars_sent    = 0;
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               quiet_cycles  = 0;

	decimal_token_parser_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[31:0], m_tdata[61:32]);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= StallLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_beat(input logic [CharW-1:0] c, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_char(c, last);
		chars_sent++;
	endtask

	task automatic send_token();
		for (int i = 0; i < token_chars.size(); i++)
			send_beat(token_chars[i], i == token_chars.size() - 1);
	endtask

	task automatic send_text(input string s);
		token_chars.delete();
		for (int i = 0; i < s.len(); i++)
			token_chars.push_back(s[i]);
		send_token();
	endtask

	task automatic add_digits(input int n);
		repeat (n) token_chars.push_back(ZeroChar + 8'($urandom_range(9)));
	endtask

	// mostly well-formed numbers, some damaged ones, some raw noise
	task automatic build_random_token();
		string near_max;
		int    pick;
		int    pos;
		near_max = "429496729";
		token_chars.delete();
		pick = $urandom_range(99);
		if (pick < 30) begin
			add_digits($urandom_range(1, 10));
		end else if (pick < 36) begin
			// last digit decides whether the integral part overflows
			for (int i = 0; i < near_max.len(); i++)
				token_chars.push_back(near_max[i]);
			add_digits(1);
			if ($urandom_range(1)) begin
				token_chars.push_back(DotChar);
				add_digits($urandom_range(0, 9));
			end
		end else if (pick < 88) begin
			add_digits(($urandom_range(3) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 3));
			token_chars.push_back(DotChar);
			add_digits($urandom_range(0, 10));
			if (pick >= 75) begin
				pos = $urandom_range(token_chars.size() - 1);
				if ($urandom_range(1))
					token_chars[pos] = 8'($urandom_range(255));
				else
					token_chars.insert(pos, DotChar);
			end
		end else begin
			repeat ($urandom_range(1, 5)) token_chars.push_back(8'($urandom_range(255)));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 11;
		recv_idle_pct = 50;
		send_text("4294967295");
		send_text("0");
		send_text(".");
		send_text("7.");
		send_text(".5");
		send_text("1.2");
		send_text("..");
		send_text("/");
		send_text(":");
		token_chars.delete();
		token_chars.push_back(8'h00);
		send_token();
		token_chars.delete();
		token_chars.push_back(8'hFF);
		send_token();

		while (chars_sent < 590) begin
			build_random_token();
			send_token();
		end
		send_idle_pct = 50;
		recv_idle_pct = 11;
		while (chars_sent < 1160) begin
			build_random_token();
			send_token();
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (chars_sent < 1725) begin
			build_random_token();
			send_token();
		end
		s_tvalid <= 1'b0;

		while (sb.expected_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
